// File: rtl/core/phase_to_unit_phasor_assert.svh
// Assertion macros used by the phasor generator top level.
`ifndef PHASE_TO_UNIT_PHASOR_ASSERT_SVH
`define PHASE_TO_UNIT_PHASOR_ASSERT_SVH

// cons must hold whenever ante holds, outside reset.
`define PTUP_ASSERT_IMPLY(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("phasor implication check failed");

// bad must never hold, outside reset.
`define PTUP_ASSERT_NEVER(label, clk, rst, bad) \
  label: assert property (@(posedge clk) disable iff (rst) !(bad)) \
    else $error("phasor forbidden condition seen");

`endif

// File: rtl/core/ptup_pkg.sv
// Package: shared types, widths and CORDIC constants of the phasor generator.
package ptup_pkg;

  localparam int PROD_W     = 48;   // low product bits that carry the turn
  localparam int FRAC_SHIFT = 16;   // phase fraction bits
  localparam int TURN_W     = 32;   // Q0.32 turn
  localparam int XY_W       = 33;   // Q3.30 CORDIC coordinates
  localparam int XY_FRAC    = 30;
  localparam int ANGLE_COUNT = 24;

  // round(2^32 / (2*pi)), Q0.32
  localparam logic [29:0] INV_TWO_PI = 30'd683565276;
  // CORDIC gain 0.6072529350 in Q3.30
  localparam logic signed [XY_W-1:0] CORDIC_GAIN = 33'sd652032874;

  // atan(2^-i) in Q0.32 turns
  localparam logic [TURN_W-1:0] STEP_ANGLE [ANGLE_COUNT] = '{
    32'h20000000, 32'h12E4051E, 32'h09FB385B, 32'h051111D4,
    32'h028B0D43, 32'h0145D7E1, 32'h00A2F61E, 32'h00517C55,
    32'h0028BE53, 32'h00145F2F, 32'h000A2F98, 32'h000517CC,
    32'h00028BE6, 32'h000145F3, 32'h0000A2FA, 32'h0000517D,
    32'h000028BE, 32'h0000145F, 32'h00000A30, 32'h00000518,
    32'h0000028C, 32'h00000146, 32'h000000A3, 32'h00000051
  };

  // One item as it moves down the rotation pipeline.
  typedef struct packed {
    logic                     valid;
    logic                     neg;        // negate both parts at the end
    logic                     batch_end;
    logic signed [XY_W-1:0]   x;
    logic signed [XY_W-1:0]   y;
    logic signed [TURN_W-1:0] z;          // residual angle, turns
  } rot_t;

endpackage

// File: rtl/core/phase_to_unit_phasor.sv
// Top level: phase in radians to unit phasor (cosine, sine) via pipelined CORDIC.
//
//   channel | handshake          | payload
//   --------+--------------------+------------------------------------------
//   in      | in_valid/in_ready  | phase_rad (signed Q8.16), batch_end
//   out     | out_valid/out_ready| cos_part, sin_part (Q1.15), batch_end_out
//
// One item per clock while the output is not stalled. Pipeline stages: one multiply
// stage, one round/fold stage, one stage per CORDIC iteration, one output stage.
// rst (synchronous) clears every stage's valid bit; payload is not reset.
// A stalled output freezes the whole pipeline; in_ready drops in that cycle,
// so nothing is dropped or repeated.
`include "phase_to_unit_phasor_assert.svh"

module phase_to_unit_phasor #(
  parameter int PHASE_WIDTH    = 24,
  parameter int OUT_WIDTH      = 16,
  parameter int ROTATION_STEPS = 16
) (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 in_valid,
  output logic                 in_ready,
  input  logic [PHASE_WIDTH-1:0] phase_rad,
  input  logic                 batch_end,
  output logic                 out_valid,
  input  logic                 out_ready,
  output logic [OUT_WIDTH-1:0] cos_part,
  output logic [OUT_WIDTH-1:0] sin_part,
  output logic                 batch_end_out
);

  // Pipeline advances unless a finished item waits at the output.
  logic en;
  assign en       = !out_valid || out_ready;
  assign in_ready = en;

  // pipe[0] leaves the fold stage, pipe[k] leaves CORDIC iteration k-1
  ptup_pkg::rot_t pipe [ROTATION_STEPS+1];

  ptup_turn #(
    .PHASE_WIDTH (PHASE_WIDTH)
  ) u_turn (
    .clk       (clk),
    .rst       (rst),
    .en        (en),
    .in_valid  (in_valid),
    .phase_rad (phase_rad),
    .batch_end (batch_end),
    .q         (pipe[0])
  );

  // One rotation stage per iteration; shift and step angle fixed per stage.
  for (genvar g = 0; g < ROTATION_STEPS; g++) begin : g_rot
    ptup_rot_stage #(
      .STEP (g)
    ) u_stage (
      .clk (clk),
      .rst (rst),
      .en  (en),
      .d   (pipe[g]),
      .q   (pipe[g+1])
    );
  end

  ptup_round_sat #(
    .OUT_WIDTH (OUT_WIDTH)
  ) u_out (
    .clk           (clk),
    .rst           (rst),
    .en            (en),
    .d             (pipe[ROTATION_STEPS]),
    .out_valid     (out_valid),
    .cos_part      (cos_part),
    .sin_part      (sin_part),
    .batch_end_out (batch_end_out)
  );

  // Fold leaves the residual angle within a quarter turn either way.
  `PTUP_ASSERT_IMPLY(a_fold_range, clk, rst, pipe[0].valid,
                     pipe[0].z[ptup_pkg::TURN_W-1] == pipe[0].z[ptup_pkg::TURN_W-2])
  // A result only appears when the pipeline has just advanced.
  `PTUP_ASSERT_IMPLY(a_out_from_advance, clk, rst, $rose(out_valid), $past(in_ready))
  // A unit phasor never rounds to zero in both parts.
  `PTUP_ASSERT_NEVER(a_nonzero_phasor, clk, rst,
                     out_valid && (cos_part == '0) && (sin_part == '0))

endmodule

// File: rtl/core/ptup_turn.sv
// Turn conversion: radians times 1/(2*pi), rounding, quadrant fold (two stages).
module ptup_turn #(
  parameter int PHASE_WIDTH = 24
) (
  input  logic                   clk,
  input  logic                   rst,
  input  logic                   en,
  input  logic                   in_valid,
  input  logic [PHASE_WIDTH-1:0] phase_rad,
  input  logic                   batch_end,
  output ptup_pkg::rot_t         q
);

  logic signed [PHASE_WIDTH+30:0] prod_full;
  logic signed [63:0]             prod_ext;
  logic [ptup_pkg::PROD_W-1:0]    prod;
  logic                           prod_valid;
  logic                           prod_last;
  logic [ptup_pkg::PROD_W-1:0]    rounded;
  logic [ptup_pkg::TURN_W-1:0]    turn;
  logic                           fold;

  // Stage 1: multiply; only the low 48 bits matter (modulo one turn)
  assign prod_full = $signed(phase_rad) * $signed({1'b0, ptup_pkg::INV_TWO_PI});
  assign prod_ext  = 64'(prod_full);

  always_ff @(posedge clk) begin
    if (rst) begin
      prod_valid <= 1'b0;
    end else if (en) begin
      prod_valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      prod      <= prod_ext[ptup_pkg::PROD_W-1:0];
      prod_last <= batch_end;
    end
  end

  // Stage 2: round to Q0.32 turn, fold quadrants 1 and 2 by half a turn
  assign rounded = prod + ptup_pkg::PROD_W'(1 << (ptup_pkg::FRAC_SHIFT - 1));
  assign turn    = rounded[ptup_pkg::PROD_W-1:ptup_pkg::FRAC_SHIFT];
  assign fold    = turn[ptup_pkg::TURN_W-1] ^ turn[ptup_pkg::TURN_W-2];

  always_ff @(posedge clk) begin
    if (rst) begin
      q.valid <= 1'b0;
    end else if (en) begin
      q.valid <= prod_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      q.neg       <= fold;
      q.batch_end <= prod_last;
      q.x         <= ptup_pkg::CORDIC_GAIN;
      q.y         <= '0;
      q.z         <= fold ? $signed({~turn[ptup_pkg::TURN_W-1], turn[ptup_pkg::TURN_W-2:0]})
                          : $signed(turn);
    end
  end

endmodule

// File: rtl/core/ptup_rot_stage.sv
// One CORDIC rotation-mode iteration as a pipeline stage.
module ptup_rot_stage #(
  parameter int STEP = 0
) (
  input  logic           clk,
  input  logic           rst,
  input  logic           en,
  input  ptup_pkg::rot_t d,
  output ptup_pkg::rot_t q
);

  logic signed [ptup_pkg::XY_W-1:0]   xs;
  logic signed [ptup_pkg::XY_W-1:0]   ys;
  logic signed [ptup_pkg::TURN_W-1:0] ang;
  logic                               up;

  assign xs  = d.x >>> STEP;
  assign ys  = d.y >>> STEP;
  assign ang = $signed(ptup_pkg::STEP_ANGLE[STEP]);
  assign up  = !d.z[ptup_pkg::TURN_W-1];

  always_ff @(posedge clk) begin
    if (rst) begin
      q.valid <= 1'b0;
    end else if (en) begin
      q.valid <= d.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      q.neg       <= d.neg;
      q.batch_end <= d.batch_end;
      q.x         <= up ? d.x - ys  : d.x + ys;
      q.y         <= up ? d.y + xs  : d.y - xs;
      q.z         <= up ? d.z - ang : d.z + ang;
    end
  end

endmodule

// File: rtl/core/ptup_round_sat.sv
// Output stage: sign fix, round to Q1.(OUT_WIDTH-1), saturate, output register.
module ptup_round_sat #(
  parameter int OUT_WIDTH = 16
) (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 en,
  input  ptup_pkg::rot_t       d,
  output logic                 out_valid,
  output logic [OUT_WIDTH-1:0] cos_part,
  output logic [OUT_WIDTH-1:0] sin_part,
  output logic                 batch_end_out
);

  localparam int RW = ptup_pkg::XY_W + 1;
  localparam int SH = ptup_pkg::XY_FRAC - (OUT_WIDTH - 1);
  localparam logic signed [RW-1:0] RND = RW'(1) <<< (SH - 1);
  localparam logic signed [RW-1:0] TOP = (RW'(1) <<< (OUT_WIDTH - 1)) - RW'(1);
  localparam logic signed [RW-1:0] BOT = -TOP - RW'(1);

  function automatic logic [OUT_WIDTH-1:0] finish(
    input logic signed [ptup_pkg::XY_W-1:0] v,
    input logic                             neg
  );
    logic signed [RW-1:0] ext;
    logic signed [RW-1:0] r;
    ext = RW'(v);
    if (neg) ext = -ext;
    r = (ext + RND) >>> SH;
    if (r > TOP) r = TOP;
    if (r < BOT) r = BOT;
    return r[OUT_WIDTH-1:0];
  endfunction

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (en) begin
      out_valid <= d.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      cos_part      <= finish(d.x, d.neg);
      sin_part      <= finish(d.y, d.neg);
      batch_end_out <= d.batch_end;
    end
  end

endmodule
